### design/prime_rehash_policy_defines.svh
`ifndef PRIME_REHASH_POLICY_DEFINES_SVH
`define PRIME_REHASH_POLICY_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/prp_pkg.sv
`default_nettype none

package prp_pkg;

  localparam int PRIME_COUNT_DEF = 256;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DATA_W          = 32;
  localparam int LF_W            = 24;
  localparam int ROM_DEPTH       = 256;
  localparam int ROM_IDX_W       = 8;
  localparam logic [LF_W-1:0] LF_RESET = 24'h010000;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_ELEMS = 2'd1;
  localparam logic [1:0] OP_HINT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_MUL_B,
    CMD_THR_B,
    CMD_ROM_MID,
    CMD_MUL_P,
    CMD_STEP,
    CMD_ROM_LO,
    CMD_THR_P,
    CMD_OUT
  } prp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       need;   // sum exceeds held threshold
    logic       grow;   // sum needs more buckets than current count
    logic       found;  // search interval closed
  } prp_stat_t;

  localparam logic [DATA_W-1:0] PRIME_ROM [0:ROM_DEPTH-1] = '{
    32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23, 32'd29,
    32'd31, 32'd37, 32'd41, 32'd43, 32'd47, 32'd53, 32'd59, 32'd61, 32'd67,
    32'd71, 32'd73, 32'd79, 32'd83, 32'd89, 32'd97, 32'd103, 32'd109, 32'd113,
    32'd127, 32'd137, 32'd139, 32'd149, 32'd157, 32'd167, 32'd179, 32'd193,
    32'd199, 32'd211, 32'd227, 32'd241, 32'd257, 32'd277, 32'd293, 32'd313,
    32'd337, 32'd359, 32'd383, 32'd409, 32'd439, 32'd467, 32'd503, 32'd541,
    32'd577, 32'd619, 32'd661, 32'd709, 32'd761, 32'd823, 32'd887, 32'd953,
    32'd1031, 32'd1109, 32'd1193, 32'd1289, 32'd1381, 32'd1493, 32'd1613,
    32'd1741, 32'd1879, 32'd2029, 32'd2179, 32'd2357, 32'd2549, 32'd2753,
    32'd2971, 32'd3209, 32'd3469, 32'd3739, 32'd4027, 32'd4349, 32'd4703,
    32'd5087, 32'd5503, 32'd5953, 32'd6427, 32'd6949, 32'd7517, 32'd8123,
    32'd8783, 32'd9497, 32'd10273, 32'd11113, 32'd12011, 32'd12983, 32'd14033,
    32'd15173, 32'd16411, 32'd17749, 32'd19183, 32'd20753, 32'd22447,
    32'd24281, 32'd26267, 32'd28411, 32'd30727, 32'd33223, 32'd35933,
    32'd38873, 32'd42043, 32'd45481, 32'd49201, 32'd53201, 32'd57557,
    32'd62233, 32'd67307, 32'd72817, 32'd78779, 32'd85229, 32'd92203,
    32'd99733, 32'd107897, 32'd116731, 32'd126271, 32'd136607, 32'd147793,
    32'd159871, 32'd172933, 32'd187091, 32'd202409, 32'd218971, 32'd236897,
    32'd256279, 32'd277261, 32'd299951, 32'd324503, 32'd351061, 32'd379787,
    32'd410857, 32'd444487, 32'd480881, 32'd520241, 32'd562841, 32'd608903,
    32'd658753, 32'd712697, 32'd771049, 32'd834181, 32'd902483, 32'd976369,
    32'd1056323, 32'd1142821, 32'd1236397, 32'd1337629, 32'd1447153,
    32'd1565659, 32'd1693859, 32'd1832561, 32'd1982627, 32'd2144977,
    32'd2320627, 32'd2510653, 32'd2716249, 32'd2938679, 32'd3179303,
    32'd3439651, 32'd3721303, 32'd4026031, 32'd4355707, 32'd4712381,
    32'd5098259, 32'd5515729, 32'd5967347, 32'd6456007, 32'd6984629,
    32'd7556579, 32'd8175383, 32'd8844859, 32'd9569143, 32'd10352717,
    32'd11200489, 32'd12117689, 32'd13109983, 32'd14183539, 32'd15345007,
    32'd16601593, 32'd17961079, 32'd19431899, 32'd21023161, 32'd22744717,
    32'd24607243, 32'd26622317, 32'd28802401, 32'd31160981, 32'd33712729,
    32'd36473443, 32'd39460231, 32'd42691603, 32'd46187573, 32'd49969847,
    32'd54061849, 32'd58488943, 32'd63278561, 32'd68460391, 32'd74066549,
    32'd80131819, 32'd86693767, 32'd93793069, 32'd101473717, 32'd109783337,
    32'd118773397, 32'd128499677, 32'd139022417, 32'd150406843, 32'd162723577,
    32'd176048909, 32'd190465427, 32'd206062531, 32'd222936881, 32'd241193053,
    32'd260944219, 32'd282312799, 32'd305431229, 32'd330442829, 32'd357502601,
    32'd386778277, 32'd418451333, 32'd452718089, 32'd489790921, 32'd529899637,
    32'd573292817, 32'd620239453, 32'd671030513, 32'd725980837, 32'd785430967,
    32'd849749479, 32'd919334987, 32'd994618837, 32'd1076067617,
    32'd1164186217, 32'd1259520799, 32'd1362662261, 32'd1474249943,
    32'd1594975441, 32'd1725587117, 32'd1866894511, 32'd2019773507,
    32'd2185171673, 32'd2364114217, 32'd2557710269, 32'd2767159799,
    32'd2993761039, 32'd3238918481, 32'd3504151727, 32'd3791104843,
    32'd4101556399, 32'd4294967291
  };

  function automatic logic [DATA_W-1:0] prime_at(input logic [ROM_IDX_W-1:0] idx);
    prime_at = PRIME_ROM[idx];
  endfunction

endpackage

`default_nettype wire

### design/prp_ctrl.sv
`default_nettype none
`include "prime_rehash_policy_defines.svh"

module prp_ctrl
  import prp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire prp_stat_t stat,
  output prp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULB,
    S_DECIDE,
    S_THRB,
    S_ROM,
    S_MULP,
    S_STEP,
    S_MULF,
    S_THRF,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_MULB;
        end
      end
      S_MULB: begin
        cmd       = CMD_MUL_B;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (stat.op)
          OP_CHECK: begin
            if (!stat.need) begin
              state_nxt = S_DONE;
            end else if (stat.grow) begin
              state_nxt = S_ROM;
            end else begin
              state_nxt = S_THRB;
            end
          end
          OP_ELEMS, OP_HINT: state_nxt = S_ROM;
          default:           state_nxt = S_DONE;
        endcase
      end
      S_THRB: begin
        cmd       = CMD_THR_B;
        state_nxt = S_DONE;
      end
      S_ROM: begin
        if (stat.found) begin
          cmd       = CMD_ROM_LO;
          state_nxt = S_MULF;
        end else begin
          cmd       = CMD_ROM_MID;
          state_nxt = S_MULP;
        end
      end
      S_MULP: begin
        cmd       = CMD_MUL_P;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd       = CMD_STEP;
        state_nxt = S_ROM;
      end
      S_MULF: begin
        cmd       = CMD_MUL_P;
        state_nxt = S_THRF;
      end
      S_THRF: begin
        cmd       = CMD_THR_P;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd           = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PRP_ASSERT_NXT(a_done_sets_valid, state_r == S_DONE && out_free, out_valid_r, "result word lost")
  `PRP_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == S_MULB, "accept did not start work")
  `PRP_ASSERT_NXT(a_nop_skips, state_r == S_DECIDE && stat.op == OP_NONE, state_r == S_DONE, "opcode 3 entered search")
  `PRP_ASSERT_NOW(a_held_result, out_valid_r && out_stall && state_r == S_DONE, cmd == CMD_IDLE, "stalled word overwritten")

endmodule

`default_nettype wire

### design/prp_dp.sv
`default_nettype none

module prp_dp
  import prp_pkg::*;
#(
  parameter int PRIME_COUNT = PRIME_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prp_cmd_t          cmd,
  output prp_stat_t              stat,
  input  wire logic              cfg_we,
  input  wire logic [LF_W-1:0]   cfg_wdata,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [DATA_W-1:0] in_bucket_count,
  input  wire logic [DATA_W-1:0] in_element_count,
  input  wire logic [DATA_W-1:0] in_add_count,
  input  wire logic [DATA_W-1:0] in_bucket_hint,
  output logic                   out_rehash,
  output logic [DATA_W-1:0]      out_new_bucket_count,
  output logic [DATA_W-1:0]      out_resize_threshold
);

  localparam int IDX_W = $clog2(PRIME_COUNT);
  localparam int PW    = DATA_W + LF_W;                 // product width
  localparam int SW    = DATA_W + 1 + FRAC_BITS;         // scaled sum width
  localparam int CW    = (SW > PW + 1) ? SW : PW + 1;    // compare width
  localparam int QW    = PW + 1 - FRAC_BITS;             // threshold quotient width

  logic [LF_W-1:0]   lf_r;
  logic [1:0]        op_r;
  logic [DATA_W-1:0] bk_r, el_r, hint_r, limit_r, p_r;
  logic [DATA_W:0]   sum_r;
  logic [PW-1:0]     prod_r;
  logic [IDX_W-1:0]  lo_r, hi_r;
  logic              res_rh_r;
  logic [DATA_W-1:0] res_nbc_r;
  logic              out_rehash_r;
  logic [DATA_W-1:0] out_nbc_r, out_thr_r;

  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [DATA_W-1:0] mul_a;
  logic [CW-1:0]     scaled_w, prod_w, lf_w, elems_w;
  logic [PW:0]       tsum;
  logic [QW-1:0]     tq;
  logic [DATA_W-1:0] thr;
  logic              pred;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[IDX_W:1];
  assign mul_a    = (cmd == CMD_MUL_B) ? bk_r : p_r;
  assign scaled_w = CW'({sum_r, {FRAC_BITS{1'b0}}});
  assign elems_w  = CW'({el_r, {FRAC_BITS{1'b0}}});
  assign prod_w   = CW'(prod_r);
  assign lf_w     = CW'(lf_r);

  // ceil(prod / 2^F), saturated
  assign tsum = {1'b0, prod_r} + {{(PW + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  assign tq   = tsum[PW:FRAC_BITS];
  assign thr  = (|tq[QW-1:DATA_W]) ? {DATA_W{1'b1}} : tq[DATA_W-1:0];

  // p >= target, with the division folded into the product compare
  always_comb begin
    case (op_r)
      OP_CHECK: pred = (prod_w >= scaled_w) && ({1'b0, p_r} >= {bk_r, 1'b0});
      OP_ELEMS: pred = (prod_w + lf_w) > elems_w;
      OP_HINT:  pred = (p_r >= hint_r);
      default:  pred = 1'b0;
    endcase
  end

  assign stat.op    = op_r;
  assign stat.need  = sum_r > {1'b0, limit_r};
  assign stat.grow  = (lf_r == '0) ? (sum_r != '0) : (scaled_w > prod_w);
  assign stat.found = (lo_r == hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r    <= LF_RESET;
      limit_r <= '0;
      op_r    <= OP_NONE;
      lo_r    <= '0;
      hi_r    <= '0;
    end else begin
      if (cfg_we) begin
        lf_r <= cfg_wdata;
      end
      case (cmd)
        CMD_LOAD: begin
          op_r <= in_opcode;
          lo_r <= '0;
          hi_r <= IDX_W'(PRIME_COUNT - 1);
        end
        CMD_STEP: begin
          if (pred) begin
            hi_r <= mid;
          end else begin
            lo_r <= mid + 1'b1;
          end
        end
        CMD_THR_B, CMD_THR_P: limit_r <= thr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        bk_r      <= (in_bucket_count == DATA_W'(1)) ? '0 : in_bucket_count;
        el_r      <= in_element_count;
        hint_r    <= in_bucket_hint;
        sum_r     <= {1'b0, in_element_count} + {1'b0, in_add_count};
        res_rh_r  <= 1'b0;
        res_nbc_r <= '0;
      end
      CMD_MUL_B, CMD_MUL_P: prod_r <= PW'(mul_a) * PW'(lf_r);
      CMD_ROM_MID:          p_r <= prime_at(ROM_IDX_W'(mid));
      CMD_ROM_LO:           p_r <= prime_at(ROM_IDX_W'(lo_r));
      CMD_THR_P: begin
        res_nbc_r <= p_r;
        res_rh_r  <= (op_r == OP_CHECK);
      end
      CMD_OUT: begin
        out_rehash_r <= res_rh_r;
        out_nbc_r    <= res_nbc_r;
        out_thr_r    <= limit_r;
      end
      default: ;
    endcase
  end

  assign out_rehash           = out_rehash_r;
  assign out_new_bucket_count = out_nbc_r;
  assign out_resize_threshold = out_thr_r;

endmodule

`default_nettype wire

### design/prime_rehash_policy.sv
// A prime search goes from accept through the bucket multiply, the decision, the search steps
// and a final ROM read, multiply and threshold to out_valid; opcode 3 or a check below
// threshold skips to the output, a refresh does only the threshold. A new word is accepted
// only once the last is done; a search step is a ROM read, a shared 32x24 multiply and compare.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_n low, synchronous): threshold 0, load factor 1.0, channels empty.
`default_nettype none

module prime_rehash_policy
  import prp_pkg::*;
#(
  parameter int PRIME_COUNT = PRIME_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [LF_W-1:0]   cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [DATA_W-1:0] in_bucket_count,
  input  wire logic [DATA_W-1:0] in_element_count,
  input  wire logic [DATA_W-1:0] in_add_count,
  input  wire logic [DATA_W-1:0] in_bucket_hint,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_rehash,
  output logic [DATA_W-1:0]      out_new_bucket_count,
  output logic [DATA_W-1:0]      out_resize_threshold
);

  prp_cmd_t  cmd;
  prp_stat_t stat;

  prp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  prp_dp #(
    .PRIME_COUNT (PRIME_COUNT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_opcode            (in_opcode),
    .in_bucket_count      (in_bucket_count),
    .in_element_count     (in_element_count),
    .in_add_count         (in_add_count),
    .in_bucket_hint       (in_bucket_hint),
    .out_rehash           (out_rehash),
    .out_new_bucket_count (out_new_bucket_count),
    .out_resize_threshold (out_resize_threshold)
  );

endmodule

`default_nettype wire

### test/prime_rehash_policy_test.sv
module prime_rehash_policy_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prp_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE = 40;

  localparam logic [31:0] PRIMES [256] = '{
    32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23, 32'd29,
    32'd31, 32'd37, 32'd41, 32'd43, 32'd47, 32'd53, 32'd59, 32'd61, 32'd67,
    32'd71, 32'd73, 32'd79, 32'd83, 32'd89, 32'd97, 32'd103, 32'd109, 32'd113,
    32'd127, 32'd137, 32'd139, 32'd149, 32'd157, 32'd167, 32'd179, 32'd193,
    32'd199, 32'd211, 32'd227, 32'd241, 32'd257, 32'd277, 32'd293, 32'd313,
    32'd337, 32'd359, 32'd383, 32'd409, 32'd439, 32'd467, 32'd503, 32'd541,
    32'd577, 32'd619, 32'd661, 32'd709, 32'd761, 32'd823, 32'd887, 32'd953,
    32'd1031, 32'd1109, 32'd1193, 32'd1289, 32'd1381, 32'd1493, 32'd1613,
    32'd1741, 32'd1879, 32'd2029, 32'd2179, 32'd2357, 32'd2549, 32'd2753,
    32'd2971, 32'd3209, 32'd3469, 32'd3739, 32'd4027, 32'd4349, 32'd4703,
    32'd5087, 32'd5503, 32'd5953, 32'd6427, 32'd6949, 32'd7517, 32'd8123,
    32'd8783, 32'd9497, 32'd10273, 32'd11113, 32'd12011, 32'd12983, 32'd14033,
    32'd15173, 32'd16411, 32'd17749, 32'd19183, 32'd20753, 32'd22447,
    32'd24281, 32'd26267, 32'd28411, 32'd30727, 32'd33223, 32'd35933,
    32'd38873, 32'd42043, 32'd45481, 32'd49201, 32'd53201, 32'd57557,
    32'd62233, 32'd67307, 32'd72817, 32'd78779, 32'd85229, 32'd92203,
    32'd99733, 32'd107897, 32'd116731, 32'd126271, 32'd136607, 32'd147793,
    32'd159871, 32'd172933, 32'd187091, 32'd202409, 32'd218971, 32'd236897,
    32'd256279, 32'd277261, 32'd299951, 32'd324503, 32'd351061, 32'd379787,
    32'd410857, 32'd444487, 32'd480881, 32'd520241, 32'd562841, 32'd608903,
    32'd658753, 32'd712697, 32'd771049, 32'd834181, 32'd902483, 32'd976369,
    32'd1056323, 32'd1142821, 32'd1236397, 32'd1337629, 32'd1447153,
    32'd1565659, 32'd1693859, 32'd1832561, 32'd1982627, 32'd2144977,
    32'd2320627, 32'd2510653, 32'd2716249, 32'd2938679, 32'd3179303,
    32'd3439651, 32'd3721303, 32'd4026031, 32'd4355707, 32'd4712381,
    32'd5098259, 32'd5515729, 32'd5967347, 32'd6456007, 32'd6984629,
    32'd7556579, 32'd8175383, 32'd8844859, 32'd9569143, 32'd10352717,
    32'd11200489, 32'd12117689, 32'd13109983, 32'd14183539, 32'd15345007,
    32'd16601593, 32'd17961079, 32'd19431899, 32'd21023161, 32'd22744717,
    32'd24607243, 32'd26622317, 32'd28802401, 32'd31160981, 32'd33712729,
    32'd36473443, 32'd39460231, 32'd42691603, 32'd46187573, 32'd49969847,
    32'd54061849, 32'd58488943, 32'd63278561, 32'd68460391, 32'd74066549,
    32'd80131819, 32'd86693767, 32'd93793069, 32'd101473717, 32'd109783337,
    32'd118773397, 32'd128499677, 32'd139022417, 32'd150406843, 32'd162723577,
    32'd176048909, 32'd190465427, 32'd206062531, 32'd222936881, 32'd241193053,
    32'd260944219, 32'd282312799, 32'd305431229, 32'd330442829, 32'd357502601,
    32'd386778277, 32'd418451333, 32'd452718089, 32'd489790921, 32'd529899637,
    32'd573292817, 32'd620239453, 32'd671030513, 32'd725980837, 32'd785430967,
    32'd849749479, 32'd919334987, 32'd994618837, 32'd1076067617,
    32'd1164186217, 32'd1259520799, 32'd1362662261, 32'd1474249943,
    32'd1594975441, 32'd1725587117, 32'd1866894511, 32'd2019773507,
    32'd2185171673, 32'd2364114217, 32'd2557710269, 32'd2767159799,
    32'd2993761039, 32'd3238918481, 32'd3504151727, 32'd3791104843,
    32'd4101556399, 32'd4294967291
  };

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] buckets;
    logic [DATA_W-1:0] elems;
    logic [DATA_W-1:0] adds;
    logic [DATA_W-1:0] hint;
    logic              drain;  // hold this word until all answers are back
  } size_req_t;

  typedef struct packed {
    logic              rehash;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] limit;
  } size_ans_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LF_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = '0;
  logic [DATA_W-1:0] in_bucket_count = '0;
  logic [DATA_W-1:0] in_element_count = '0;
  logic [DATA_W-1:0] in_add_count = '0;
  logic [DATA_W-1:0] in_bucket_hint = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_rehash;
  logic [DATA_W-1:0] out_new_bucket_count;
  logic [DATA_W-1:0] out_resize_threshold;

  size_req_t requests_q[$];
  size_ans_t answers_due[$];

  // checking side state
  logic [LF_W-1:0]   lf_live = LF_RESET;
  logic [DATA_W-1:0] limit_live = '0;
  // generation side shadow, used only to steer stimulus
  logic [LF_W-1:0]   gen_lf = LF_RESET;
  logic [DATA_W-1:0] gen_limit = '0;

  size_req_t cur_req;
  size_ans_t fresh_ans;
  size_ans_t want;
  logic      in_idle_on = 1'b1;
  logic      out_idle_on = 1'b1;
  int        in_pause = 0;
  int        hold_left = 0;
  int        errors = 0;
  int        planned = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        grows = 0;
  int        settings = 1;

  always #5 clk = ~clk;

  prime_rehash_policy u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_bucket_count      (in_bucket_count),
    .in_element_count     (in_element_count),
    .in_add_count         (in_add_count),
    .in_bucket_hint       (in_bucket_hint),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_rehash           (out_rehash),
    .out_new_bucket_count (out_new_bucket_count),
    .out_resize_threshold (out_resize_threshold)
  );

  function automatic logic [31:0] first_prime_from(logic [63:0] target);
    for (int i = 0; i < 256; i++)
      if ({32'b0, PRIMES[i]} >= target) return PRIMES[i];
    return PRIMES[255];
  endfunction

  // ceil(count * lf), saturated to 32 bits
  function automatic logic [31:0] limit_for(logic [31:0] c, logic [LF_W-1:0] lf);
    logic [63:0] prod;
    prod = {32'b0, c} * {40'b0, lf};
    prod = (prod + ((64'd1 << FRAC) - 64'd1)) >> FRAC;
    return (prod[63:32] != 0) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic size_ans_t sizing_answer(size_req_t r, logic [LF_W-1:0] lf,
                                              logic [31:0] limit);
    logic [63:0] sum, scaled, have, target, twice, lf64;
    logic [31:0] b;
    size_ans_t a;
    a = '0;
    a.limit = limit;
    lf64 = {40'b0, lf};
    case (r.op)
      OP_CHECK: begin
        sum = {32'b0, r.elems} + {32'b0, r.adds};
        if (sum > {32'b0, limit}) begin
          scaled = sum << FRAC;
          b = (r.buckets == 32'd1) ? 32'd0 : r.buckets;
          have = {32'b0, b} * lf64;
          if ((lf == 0) ? (scaled != 0) : (scaled > have)) begin
            // zero load factor: need is beyond every prime
            target = (lf == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (scaled + lf64 - 64'd1) / lf64;
            twice = {32'b0, b} << 1;
            if (twice > target) target = twice;
            a.count = first_prime_from(target);
            a.limit = limit_for(a.count, lf);
            a.rehash = 1'b1;
          end else begin
            a.limit = limit_for(b, lf);
          end
        end
      end
      OP_ELEMS: begin
        target = (lf == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : ({32'b0, r.elems} << FRAC) / lf64;
        a.count = first_prime_from(target);
        a.limit = limit_for(a.count, lf);
      end
      OP_HINT: begin
        a.count = first_prime_from({32'b0, r.hint});
        a.limit = limit_for(a.count, lf);
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic size_req_t word_of(logic [1:0] op, logic [31:0] b, logic [31:0] e,
                                        logic [31:0] a, logic [31:0] h);
    size_req_t r;
    r.op = op;
    r.buckets = b;
    r.elems = e;
    r.adds = a;
    r.hint = h;
    r.drain = 1'b0;
    return r;
  endfunction

  // small magnitudes most of the time
  function automatic logic [31:0] spread();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4, 5: return $urandom;
      default: return spread();
    endcase
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_val);
    errors++;
    $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  task automatic issue(input size_req_t r, output size_ans_t a);
    if ($urandom_range(0, 199) == 0) r.drain = 1'b1;
    a = sizing_answer(r, gen_lf, gen_limit);
    gen_limit = a.limit;
    requests_q.push_back(r);
    if (r.op != OP_NONE) planned++;
  endtask

  // a table that is sized, then filled up to and past its threshold
  task automatic grow_table(int steps);
    size_ans_t a;
    logic [31:0] b, e, room, adds;
    logic [32:0] t;
    issue(word_of(OP_HINT, $urandom, $urandom, $urandom, $urandom >> $urandom_range(8, 31)), a);
    b = a.count;
    e = $urandom_range(0, gen_limit);
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 5) == 0) begin
        issue(word_of(OP_ELEMS, $urandom, e, $urandom, $urandom), a);
        b = a.count;
      end else begin
        room = (gen_limit > e) ? gen_limit - e : 32'd0;
        case ($urandom_range(0, 3))
          0: t = {1'b0, room};
          1: t = {1'b0, room} + 33'd1 + 33'($urandom_range(0, 3));
          2: t = 33'($urandom_range(0, 8));
          default: t = {1'b0, spread()};
        endcase
        adds = t[32] ? 32'hFFFF_FFFF : t[31:0];
        // mostly the true bucket count, sometimes a broken one
        case ($urandom_range(0, 11))
          0: issue(word_of(OP_CHECK, 32'd1, e, adds, $urandom), a);
          1: issue(word_of(OP_CHECK, any_value(), e, adds, $urandom), a);
          default: issue(word_of(OP_CHECK, b, e, adds, $urandom), a);
        endcase
        if (a.rehash) b = a.count;
        t = {1'b0, e} + {1'b0, adds};
        e = t[32] ? $urandom_range(0, gen_limit) : t[31:0];
      end
    end
  endtask

  task automatic fill_random(int n);
    size_ans_t a;
    int start;
    start = planned;
    while (planned - start < n) begin
      if ($urandom_range(0, 9) < 7)
        grow_table($urandom_range(4, 20));
      else
        issue(word_of(2'($urandom_range(0, 3)), any_value(), any_value(), any_value(),
                      any_value()), a);
    end
  endtask

  task automatic wait_quiet();
    while (requests_q.size() != 0 || in_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_load_factor(logic [LF_W-1:0] v);
    wait_quiet();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lf_live = v;
    gen_lf = v;
    settings++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pause = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fresh_ans = sizing_answer(cur_req, lf_live, limit_live);
        limit_live = fresh_ans.limit;
        answers_due.push_back(fresh_ans);
        words_in++;
        if (fresh_ans.rehash) grows++;
        if (in_idle_on) in_pause = pick_pause();
      end
      if (!in_valid || !in_stall) begin
        if (in_pause > 0) begin
          in_pause--;
          in_valid <= 1'b0;
        end else if (requests_q.size() != 0 &&
                     !(requests_q[0].drain && answers_due.size() != 0)) begin
          cur_req = requests_q.pop_front();
          in_opcode <= cur_req.op;
          in_bucket_count <= cur_req.buckets;
          in_element_count <= cur_req.elems;
          in_add_count <= cur_req.adds;
          in_bucket_hint <= cur_req.hint;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (answers_due.size() == 0) begin
          report("word with nothing pending, new_bucket_count", out_new_bucket_count, '0);
        end else begin
          want = answers_due.pop_front();
          if (out_rehash !== want.rehash)
            report("rehash", 32'(out_rehash), 32'(want.rehash));
          if (out_new_bucket_count !== want.count)
            report("new_bucket_count", out_new_bucket_count, want.count);
          if (out_resize_threshold !== want.limit)
            report("resize_threshold", out_resize_threshold, want.limit);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_idle_on) hold_left = pick_pause();
      end
    end
  end

  initial begin
    size_ans_t a;
    size_req_t r;
    logic [LF_W-1:0] lf_next;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // held threshold starts at zero, load factor 1.0
    issue(word_of(OP_CHECK, 32'd0, 32'd0, 32'd0, 32'd0), a);   // sum not above limit
    issue(word_of(OP_CHECK, 32'd1, 32'd0, 32'd1, 32'd0), a);   // one bucket counts as none
    issue(word_of(OP_CHECK, 32'd2, 32'd1, 32'd1, 32'd0), a);   // sum equals limit
    issue(word_of(OP_CHECK, 32'd2, 32'd2, 32'd1, 32'd0), a);   // doubling wins
    issue(word_of(OP_CHECK, 32'd100, 32'd5, 32'd1, 32'd0), a); // refresh, no growth
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd0), a);
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd3), a);
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd4294967291), a);
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF), a); // past the last prime
    issue(word_of(OP_ELEMS, 32'd0, 32'd0, 32'd0, 32'd0), a);
    issue(word_of(OP_ELEMS, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0), a);
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd0), a);
    issue(word_of(OP_CHECK, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0), a); // no wrap
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd0), a);
    issue(word_of(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0), a);
    r = word_of(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.drain = 1'b1;
    issue(r, a);
    issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd1000), a);
    issue(word_of(OP_CHECK, 32'd1009, 32'd1009, 32'd5, 32'd0), a);
    issue(word_of(OP_ELEMS, 32'd0, 32'd1000, 32'd0, 32'd0), a);
    fill_random(250);

    for (int p = 1; p < 9; p++) begin
      case (p)
        1: lf_next = 24'h008000;
        2: lf_next = 24'hFFFFFF;
        3: lf_next = 24'h000001;
        4: lf_next = 24'h000000;
        5: lf_next = 24'h018000;
        6: lf_next = LF_W'($urandom_range(1, 24'hFFFFFF));
        7: lf_next = LF_W'($urandom_range(1, 4096));
        default: lf_next = LF_RESET;
      endcase
      write_load_factor(lf_next);
      in_idle_on = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      out_idle_on = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      if (lf_next == 24'hFFFFFF)
        issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF), a); // threshold saturates
      if (lf_next == 24'h000000) begin
        issue(word_of(OP_CHECK, 32'd0, 32'd0, 32'd0, 32'd0), a);
        issue(word_of(OP_CHECK, 32'd0, 32'd0, 32'd1, 32'd0), a);
        issue(word_of(OP_ELEMS, 32'd0, 32'd0, 32'd0, 32'd0), a);
        issue(word_of(OP_HINT, 32'd0, 32'd0, 32'd0, 32'd5), a);
      end
      fill_random((p == 4) ? 40 : 250);
    end

    wait_quiet();
    $display("%0d sizing words checked (%0d results) across %0d load factor settings,",
             words_in, words_out, settings);
    $display("%0d of them grew the table", grows);
    if (errors == 0)
      $display("prime_rehash_policy: match");
    else
      $display("prime_rehash_policy: mismatch");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout waiting for results");
    $display("prime_rehash_policy: mismatch");
    $finish;
  end

endmodule
